/* hdl/rag_pkg.sv */
// rag_pkg: shared types, constants and fixed-point helpers for the radial apodisation gain block
// used by rag_cos_chain, rag_exp_chain and radial_apodization_gain
// no dependencies
package rag_pkg;

	localparam int RADIAL_POINTS = 1024;
	localparam int IDX_W = 10;
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(RADIAL_POINTS - 1);

	localparam logic [15:0] ONE_Q15 = 16'h8000;

	// cosine polynomial coefficients, innermost first
	localparam logic [15:0] COS_C0 = 16'd30;
	localparam logic [15:0] COS_C1 = 16'd684;
	localparam logic [15:0] COS_C2 = 16'd8312;
	localparam logic [15:0] COS_C3 = 16'd40426;
	localparam int COS_LAT = 8;

	localparam int EXP_STEPS = 7;
	localparam int EXP_LAT = 3 * EXP_STEPS + 2;
	localparam int TAPER_DLY = EXP_LAT - COS_LAT;

	typedef enum logic [2:0] {
		MODE_DENSITY  = 3'd0,
		MODE_APERTURE = 3'd1,
		MODE_MASK     = 3'd2,
		MODE_TAPER    = 3'd3,
		MODE_GAUSS    = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		REG_FILTER_MODE   = 3'd0,
		REG_DENSITY_GAIN  = 3'd1,
		REG_INNER_RADIUS  = 3'd2,
		REG_EDGE_WIDTH    = 3'd3,
		REG_INVERSE_WIDTH = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		SRC_CONST = 2'd0,
		SRC_TAPER = 2'd1,
		SRC_GAUSS = 2'd2
	} src_t;

	typedef struct packed {
		logic [15:0] re;
		logic [15:0] im;
		src_t        src;
		logic [15:0] cgain;
	} item_t;

	// round-to-nearest drop of 15 fraction bits
	function automatic logic [20:0] rnd_q15(input logic [35:0] x);
		return 21'((x + 36'd16384) >> 15);
	endfunction

	// round(32768 * exp(-n))
	function automatic logic [15:0] exp_int(input logic [3:0] n);
		logic [15:0] e;
		case (n)
			4'd0:    e = 16'd32768;
			4'd1:    e = 16'd12055;
			4'd2:    e = 16'd4435;
			4'd3:    e = 16'd1631;
			4'd4:    e = 16'd600;
			4'd5:    e = 16'd221;
			4'd6:    e = 16'd81;
			4'd7:    e = 16'd30;
			4'd8:    e = 16'd11;
			4'd9:    e = 16'd4;
			4'd10:   e = 16'd1;
			4'd11:   e = 16'd1;
			default: e = 16'd0;
		endcase
		return e;
	endfunction

endpackage

/* hdl/rag_cos_chain.sv */
// rag_cos_chain: eight-stage pipelined quarter-wave cosine, cos(pi/2*u) from v = u^2 in Q1.15
// depends on rag_pkg
module rag_cos_chain (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] v,
	output logic [15:0] gain
);

	logic [15:0] v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [31:0] m_s1, m_s3, m_s5, m_s7;
	logic [15:0] t_s2, t_s4, t_s6;
	logic [15:0] gain_s8;
	logic [20:0] p_fin;

	assign p_fin = rag_pkg::rnd_q15({4'b0, m_s7});

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= {16'b0, v} * {16'b0, rag_pkg::COS_C0};
			v_s1 <= v;
			t_s2 <= rag_pkg::COS_C1 - 16'(rag_pkg::rnd_q15({4'b0, m_s1}));
			v_s2 <= v_s1;
			m_s3 <= {16'b0, v_s2} * {16'b0, t_s2};
			v_s3 <= v_s2;
			t_s4 <= rag_pkg::COS_C2 - 16'(rag_pkg::rnd_q15({4'b0, m_s3}));
			v_s4 <= v_s3;
			m_s5 <= {16'b0, v_s4} * {16'b0, t_s4};
			v_s5 <= v_s4;
			t_s6 <= rag_pkg::COS_C3 - 16'(rag_pkg::rnd_q15({4'b0, m_s5}));
			v_s6 <= v_s5;
			m_s7 <= {16'b0, v_s6} * {16'b0, t_s6};
			// clamp at zero past the quarter wave
			gain_s8 <= (p_fin >= 21'(rag_pkg::ONE_Q15)) ? 16'd0 :
				rag_pkg::ONE_Q15 - p_fin[15:0];
		end
	end

	assign gain = gain_s8;

endmodule

/* hdl/rag_exp_chain.sv */
// rag_exp_chain: pipelined exp(-q) for q = n + f, seven Horner steps of three stages each
// plus the integer-part table product; depends on rag_pkg
module rag_exp_chain (
	input  logic        clk,
	input  logic        en,
	input  logic [14:0] frac,
	input  logic [3:0]  whole,
	output logic [15:0] gain
);

	localparam int STEPS = rag_pkg::EXP_STEPS;

	logic [15:0] q_link [STEPS+1];
	logic [14:0] f_link [STEPS+1];
	logic [3:0]  n_link [STEPS+1];

	assign q_link[0] = 16'd0;
	assign f_link[0] = frac;
	assign n_link[0] = whole;

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int K = STEPS - j;
		localparam logic [30:0] BIAS = 31'(K * 16384);
		// exact floor(y/K) for y below 2^16
		localparam logic [19:0] RECIP = 20'(((1 << 19) + K - 1) / K);

		logic [30:0] prod_s1;
		logic [15:0] y_s2;
		logic [35:0] z_s3;
		logic [14:0] f_s1, f_s2, f_s3;
		logic [3:0]  n_s1, n_s2, n_s3;

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1 <= {16'b0, f_link[j]} * {15'b0, rag_pkg::ONE_Q15 - q_link[j]};
				y_s2    <= 16'((prod_s1 + BIAS) >> 15);
				z_s3    <= {20'b0, y_s2} * {16'b0, RECIP};
				f_s1    <= f_link[j];
				f_s2    <= f_s1;
				f_s3    <= f_s2;
				n_s1    <= n_link[j];
				n_s2    <= n_s1;
				n_s3    <= n_s2;
			end
		end

		assign q_link[j+1] = z_s3[34:19];
		assign f_link[j+1] = f_s3;
		assign n_link[j+1] = n_s3;
	end

	logic [31:0] gm_s1;
	logic [15:0] gain_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			gm_s1   <= {16'b0, rag_pkg::exp_int(n_link[STEPS])} *
				{16'b0, rag_pkg::ONE_Q15 - q_link[STEPS]};
			gain_s2 <= 16'(rag_pkg::rnd_q15({4'b0, gm_s1}));
		end
	end

	assign gain = gain_s2;

endmodule

/* hdl/radial_apodization_gain.sv */
// radial_apodization_gain: top level, scales complex samples by a radial window gain
// depends on rag_pkg, rag_cos_chain and rag_exp_chain
//
// Input beats arrive on s_tvalid/s_tready with the bin index and the complex sample in
// s_tdata and the apply flag in s_tuser; scaled samples leave on m_tvalid/m_tready.
// One beat in gives exactly one beat out, in order. The window shape and its registers
// are written through cfg_we/cfg_index/cfg_data; the user must write them only while no
// beat is in flight, which the block itself does not enforce. The gaussian path (seven
// Horner steps of three stages each) sets the pipeline depth, and the taper, constant
// and pass-through paths are delayed to match it. Throughput is one beat per cycle while
// s_tready is high: every stage is registered and one item enters per cycle.
// Reset clears all valid bits and returns the registers to neutral density, unity gain.
// When the receiver holds m_tready low, the output register keeps its beat and one more
// beat falls into a skid register; s_tready then drops and the whole pipeline freezes
// until the skid drains, so no beat is lost or repeated.
module radial_apodization_gain (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // radial_index, field_re, field_im, zero pad
	input  logic        s_tuser,   // apply
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_re, out_im
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int LAT = rag_pkg::EXP_LAT;
	localparam int TDL = rag_pkg::TAPER_DLY;

	// configuration registers
	logic [2:0]  filter_mode_q;
	logic [15:0] density_gain_q;
	logic [15:0] inner_radius_q;
	logic [15:0] edge_width_q;
	logic [23:0] inverse_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q   <= rag_pkg::MODE_DENSITY;
			density_gain_q  <= rag_pkg::ONE_Q15;
			inner_radius_q  <= 16'd0;
			edge_width_q    <= 16'd16;
			inverse_width_q <= 24'd1048576;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rag_pkg::REG_FILTER_MODE:   filter_mode_q   <= cfg_data[2:0];
				rag_pkg::REG_DENSITY_GAIN:  density_gain_q  <= cfg_data[15:0];
				rag_pkg::REG_INNER_RADIUS:  inner_radius_q  <= cfg_data[15:0];
				rag_pkg::REG_EDGE_WIDTH:    edge_width_q    <= cfg_data[15:0];
				rag_pkg::REG_INVERSE_WIDTH: inverse_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic skid_valid_q, out_valid_q;
	logic [31:0] skid_q, out_q;

	assign en       = !skid_valid_q;
	assign s_tready = en;

	// stage 1 decode
	logic [rag_pkg::IDX_W-1:0]   idx_c;
	logic [rag_pkg::IDX_W+3:0]   r4;
	logic                        in_flat;
	logic [rag_pkg::IDX_W+3:0]   d_in;
	logic [15:0]                 dens;
	rag_pkg::item_t              item_in;

	always_comb begin
		idx_c   = (s_tdata[9:0] > rag_pkg::IDX_MAX) ? rag_pkg::IDX_MAX : s_tdata[9:0];
		r4      = {idx_c, 4'b1000};
		in_flat = {2'b00, r4} <= inner_radius_q;
		d_in    = r4 - inner_radius_q[rag_pkg::IDX_W+3:0];
		dens    = (density_gain_q > rag_pkg::ONE_Q15) ? rag_pkg::ONE_Q15 : density_gain_q;
		item_in.re    = s_tdata[25:10];
		item_in.im    = s_tdata[41:26];
		item_in.src   = rag_pkg::SRC_CONST;
		item_in.cgain = rag_pkg::ONE_Q15;
		unique case (filter_mode_q)
			rag_pkg::MODE_DENSITY:  item_in.cgain = dens;
			rag_pkg::MODE_APERTURE: item_in.cgain = in_flat ? rag_pkg::ONE_Q15 : 16'd0;
			rag_pkg::MODE_MASK:     item_in.cgain = in_flat ? 16'd0 : rag_pkg::ONE_Q15;
			rag_pkg::MODE_TAPER: begin
				if (!in_flat) begin
					if ({2'b00, d_in} > edge_width_q)
						item_in.cgain = 16'd0;
					else
						item_in.src = rag_pkg::SRC_TAPER;
				end
			end
			rag_pkg::MODE_GAUSS: begin
				if (!in_flat)
					item_in.src = rag_pkg::SRC_GAUSS;
			end
			default: ;
		endcase
		// pass-through is unity gain
		if (!s_tuser) begin
			item_in.src   = rag_pkg::SRC_CONST;
			item_in.cgain = rag_pkg::ONE_Q15;
		end
	end

	// pipeline payload
	rag_pkg::item_t item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [rag_pkg::IDX_W+3:0] d_s1;
	logic [37:0] prod_s2;
	logic [15:0] u_s3;
	logic [16:0] sq_s3;
	logic [31:0] uu_s4;
	logic [33:0] ss_s4;
	logic [15:0] v_s5;
	logic [3:0]  n_s5;
	logic [14:0] f_s5;
	rag_pkg::item_t dly_item_s [LAT];
	logic [15:0] tap_dly_s [TDL];
	logic [15:0] gain_s29, re_s29, im_s29;
	logic signed [32:0] pre_s30, pim_s30;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic dly_valid_s [LAT];
	logic valid_s29, valid_s30;

	logic [28:0] p_s3;
	rag_pkg::item_t item_s3_nx;
	logic [20:0] q_s5;
	logic [15:0] cos_gain, exp_gain, sel_gain;
	logic signed [32:0] sum_re, sum_im;
	logic [31:0] res;

	always_comb begin
		p_s3       = prod_s2[37:9];
		item_s3_nx = item_s2;
		// gaussian tail from s = 4 up is zero
		if (item_s2.src == rag_pkg::SRC_GAUSS && p_s3 >= 29'd131072) begin
			item_s3_nx.src   = rag_pkg::SRC_CONST;
			item_s3_nx.cgain = 16'd0;
		end
	end

	assign q_s5 = rag_pkg::rnd_q15({2'b00, ss_s4});

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_in;
			d_s1    <= d_in;
			prod_s2 <= {24'b0, d_s1} * {14'b0, inverse_width_q} + 38'd256;
			item_s2 <= item_s1;
			u_s3    <= (p_s3 > 29'd32768) ? rag_pkg::ONE_Q15 : p_s3[15:0];
			sq_s3   <= p_s3[16:0];
			item_s3 <= item_s3_nx;
			uu_s4   <= {16'b0, u_s3} * {16'b0, u_s3};
			ss_s4   <= {17'b0, sq_s3} * {17'b0, sq_s3};
			item_s4 <= item_s3;
			v_s5    <= 16'(rag_pkg::rnd_q15({4'b0, uu_s4}));
			n_s5    <= q_s5[18:15];
			f_s5    <= q_s5[14:0];
			item_s5 <= item_s4;
			dly_item_s[0] <= item_s5;
			for (int i = 1; i < LAT; i++)
				dly_item_s[i] <= dly_item_s[i-1];
			tap_dly_s[0] <= cos_gain;
			for (int i = 1; i < TDL; i++)
				tap_dly_s[i] <= tap_dly_s[i-1];
			gain_s29 <= sel_gain;
			re_s29   <= dly_item_s[LAT-1].re;
			im_s29   <= dly_item_s[LAT-1].im;
			pre_s30  <= 33'($signed(re_s29)) * 33'($signed({1'b0, gain_s29}));
			pim_s30  <= 33'($signed(im_s29)) * 33'($signed({1'b0, gain_s29}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			for (int i = 0; i < LAT; i++)
				dly_valid_s[i] <= 1'b0;
			valid_s29 <= 1'b0;
			valid_s30 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			dly_valid_s[0] <= valid_s5;
			for (int i = 1; i < LAT; i++)
				dly_valid_s[i] <= dly_valid_s[i-1];
			valid_s29 <= dly_valid_s[LAT-1];
			valid_s30 <= valid_s29;
		end
	end

	rag_cos_chain u_cos (
		.clk  (clk),
		.en   (en),
		.v    (v_s5),
		.gain (cos_gain)
	);

	rag_exp_chain u_exp (
		.clk   (clk),
		.en    (en),
		.frac  (f_s5),
		.whole (n_s5),
		.gain  (exp_gain)
	);

	always_comb begin
		case (dly_item_s[LAT-1].src)
			rag_pkg::SRC_TAPER: sel_gain = tap_dly_s[TDL-1];
			rag_pkg::SRC_GAUSS: sel_gain = exp_gain;
			default:            sel_gain = dly_item_s[LAT-1].cgain;
		endcase
	end

	assign sum_re = pre_s30 + 33'sd16384;
	assign sum_im = pim_s30 + 33'sd16384;
	assign res    = {sum_im[30:15], sum_re[30:15]};

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (en) begin
			if (valid_s30) begin
				if (!out_valid_q || m_tready)
					out_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end else if (m_tready) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (valid_s30) begin
				if (!out_valid_q || m_tready)
					out_q <= res;
				else
					skid_q <= res;
			end
		end else if (m_tready) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

/* hdl/rag_checker.sv */
// rag_checker: port-level checks on the output handshake and skid behaviour
// bound to radial_apodization_gain; no package dependency
module rag_stream_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed while stalled");

	// skid only fills behind a held output beat
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input held back with no output beat pending");

	// one accepted output beat drains the skid entry
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && m_tready |=> s_tready)
		else $error("skid entry not drained");

endmodule

bind radial_apodization_gain rag_stream_checker u_rag_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
